// ===== sv/assert_macros.svh =====
// Assertion macros used by the console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever cond holds, expr must hold as well.
`define TCW_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication: whenever cond holds, expr must hold in the cycle after.
`define TCW_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");
`else
`define TCW_ASSERT_IMP(label, clk, rst, cond, expr)
`define TCW_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ===== sv/tcw_pkg.sv =====
// Shared constants and types for the text console writer.
`default_nettype none
package tcw_pkg;
   localparam int COLS_DEF    = 80;
   localparam int ROWS_DEF    = 25;
   localparam int QUEUE_DEPTH = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int TAB_STEP    = 4;
   localparam int TAB_W       = $clog2(TAB_STEP);

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_MOVE  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_TAB,
      OP_MOVE,
      OP_READ,
      OP_CLEAR
   } op_type;

   localparam int OP_W = $bits(op_type);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic pop;
      logic init;
   } status_type;
endpackage
`default_nettype wire

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== sv/tcw_front.sv =====
// Front end: accepts requests, decodes them into operations and clamps coordinates.
`default_nettype none
module tcw_front import tcw_pkg::*; #(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF,
   localparam int COL_W = $clog2(COLS),
   localparam int ROW_W = $clog2(ROWS),
   localparam int OFF_W = $clog2(COLS * ROWS),
   localparam int ENTRY_W = OP_W + CHAR_W + COL_W + ROW_W + OFF_W
) (
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_mode,
   input  wire logic [CHAR_W-1:0]  req_char_in,
   input  wire logic [6:0]         req_col,
   input  wire logic [4:0]         req_row,
   input  wire logic               q_full,
   output logic                    q_push,
   output logic [ENTRY_W-1:0]      q_entry
);
   op_type           op;
   logic [COL_W-1:0] col_clamped;
   logic [ROW_W-1:0] row_clamped;
   logic [OFF_W-1:0] offset;

   always_comb begin
      unique case (req_mode)
         MODE_PUT: begin
            priority if (req_char_in == CH_NEWLINE) begin
               op = OP_NEWLINE;
            end else if (req_char_in == CH_TAB) begin
               op = OP_TAB;
            end else begin
               op = OP_PUT;
            end
         end
         MODE_MOVE:  op = OP_MOVE;
         MODE_READ:  op = OP_READ;
         MODE_CLEAR: op = OP_CLEAR;
      endcase
   end

   // Coordinates beyond the screen saturate to the last column or row.
   always_comb begin
      col_clamped = (int'(req_col) >= COLS) ? COL_W'(COLS - 1) : COL_W'(req_col);
      row_clamped = (int'(req_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(req_row);
      offset      = OFF_W'(col_clamped) + OFF_W'(row_clamped * COLS);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_entry   = {op, req_char_in, col_clamped, row_clamped, offset};
endmodule
`default_nettype wire

// ===== sv/tcw_queue.sv =====
// Short FIFO that decouples the decoding front end from the screen sequencer.
`default_nettype none
module tcw_queue import tcw_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output logic      [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
endmodule
`default_nettype wire

// ===== sv/tcw_back.sv =====
// Back end: screen store, cursor, scroll and clear sequencer, result register.
`default_nettype none
module tcw_back import tcw_pkg::*; #(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF,
   localparam int COL_W = $clog2(COLS),
   localparam int ROW_W = $clog2(ROWS),
   localparam int CELLS = COLS * ROWS,
   localparam int OFF_W = $clog2(CELLS),
   localparam int ENTRY_W = OP_W + CHAR_W + COL_W + ROW_W + OFF_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [ATTR_W-1:0]  attr,
   input  wire logic               q_valid,
   input  wire logic [ENTRY_W-1:0] q_data,
   output status_type              status,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [6:0]         rsp_cursor_col,
   output logic      [4:0]         rsp_cursor_row,
   output logic      [CHAR_W-1:0]  rsp_cell_char,
   output logic      [ATTR_W-1:0]  rsp_cell_attr,
   output logic                    rsp_scrolled
);
   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [OFF_W-1:0] sweep_ff, sweep_in;
   logic [ATTR_W-1:0] blank_attr_ff, blank_attr_in;
   logic             scroll_ff, scroll_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_col_ff;
   logic [4:0]       rsp_row_ff;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic             rsp_scrolled_ff, rsp_scrolled_in;
   logic             rsp_load;

   logic             ram_we;
   logic [OFF_W-1:0] ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   logic [OP_W-1:0]   q_op_bits;
   op_type            q_op;
   logic [CHAR_W-1:0] q_ch;
   logic [COL_W-1:0]  q_col;
   logic [ROW_W-1:0]  q_row;
   logic [OFF_W-1:0]  q_off;

   logic [COL_W:0]    tab_step;
   logic [COL_W:0]    adv_col;
   logic              wrap;
   logic              scroll;
   logic              pop;

   assign {q_op_bits, q_ch, q_col, q_row, q_off} = q_data;
   assign q_op = op_type'(q_op_bits);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Cursor advance for printable bytes, tabs and newlines; at most one row wrap.
   always_comb begin
      tab_step = (COL_W+1)'(TAB_STEP) - (COL_W+1)'(off_ff[TAB_W-1:0]);
      unique case (q_op)
         OP_PUT:     adv_col = {1'b0, col_ff} + 1'b1;
         OP_TAB:     adv_col = {1'b0, col_ff} + tab_step;
         default:    adv_col = (COL_W+1)'(COLS);
      endcase
      wrap   = (adv_col >= (COL_W+1)'(COLS));
      scroll = wrap && (row_ff == ROW_W'(ROWS - 1));
   end

   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      off_in          = off_ff;
      sweep_in        = sweep_ff;
      blank_attr_in   = blank_attr_ff;
      scroll_in       = scroll_ff;
      ram_we          = 1'b0;
      ram_waddr       = sweep_ff;
      ram_wdata       = {blank_attr_ff, CH_SPACE};
      ram_raddr       = OFF_W'(sweep_ff + OFF_W'(COLS));
      pop             = 1'b0;
      rsp_load        = 1'b0;
      rsp_char_in     = '0;
      rsp_attr_in     = '0;
      rsp_scrolled_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               pop = 1'b1;
               unique case (q_op)
                  OP_PUT, OP_NEWLINE, OP_TAB: begin
                     if (q_op == OP_PUT) begin
                        ram_we    = 1'b1;
                        ram_waddr = off_ff;
                        ram_wdata = {attr, q_ch};
                     end
                     if (scroll) begin
                        col_in        = '0;
                        row_in        = ROW_W'(ROWS - 1);
                        off_in        = OFF_W'(CELLS - COLS);
                        sweep_in      = '0;
                        blank_attr_in = attr;
                        scroll_in     = 1'b1;
                        state_in      = ST_COPY;
                     end else begin
                        col_in   = wrap ? COL_W'(adv_col - (COL_W+1)'(COLS)) : COL_W'(adv_col);
                        row_in   = wrap ? row_ff + 1'b1 : row_ff;
                        off_in   = off_ff + OFF_W'(adv_col - {1'b0, col_ff});
                        rsp_load = 1'b1;
                     end
                  end
                  OP_MOVE: begin
                     col_in   = q_col;
                     row_in   = q_row;
                     off_in   = q_off;
                     rsp_load = 1'b1;
                  end
                  OP_READ: begin
                     ram_raddr = q_off;
                     state_in  = ST_READ;
                  end
                  OP_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     off_in        = '0;
                     sweep_in      = '0;
                     blank_attr_in = attr;
                     scroll_in     = 1'b0;
                     state_in      = ST_FILL;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_char_in = ram_rdata[CHAR_W-1:0];
            rsp_attr_in = ram_rdata[CELL_W-1:CHAR_W];
            state_in    = ST_IDLE;
         end
         ST_COPY: begin
            // Each cycle reads one row further down and writes the cell read last cycle.
            if (sweep_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = sweep_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
            if (sweep_ff == OFF_W'(CELLS - COLS)) begin
               state_in = ST_FILL;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_INIT, ST_FILL: begin
            ram_we = 1'b1;
            if (sweep_ff == OFF_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
               if (state_ff == ST_FILL) begin
                  rsp_load        = 1'b1;
                  rsp_scrolled_in = scroll_ff;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         off_ff        <= '0;
         sweep_ff      <= '0;
         blank_attr_ff <= ATTR_RESET;
         scroll_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         off_ff        <= off_in;
         sweep_ff      <= sweep_in;
         blank_attr_ff <= blank_attr_in;
         scroll_ff     <= scroll_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff      <= 7'(col_in);
         rsp_row_ff      <= 5'(row_in);
         rsp_char_ff     <= rsp_char_in;
         rsp_attr_ff     <= rsp_attr_in;
         rsp_scrolled_ff <= rsp_scrolled_in;
      end
   end

   assign status.pop  = pop;
   assign status.init = (state_ff == ST_INIT);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
endmodule
`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
// Put, newline, tab and move pass through the queue and then the result register; a read
// also passes the registered screen RAM read. Clear blanks the whole screen; a scroll does
// a row copy, then bottom-row blanking, one cell per cycle through the single screen RAM
// port pair. The sequencer holds one transaction at a time and takes a new one only once
// the result of the last has been taken. Reset is synchronous: after it the screen is
// blanked before the first request is executed; up to two requests are queued meanwhile.
`default_nettype none
`include "assert_macros.svh"
module text_console_writer_unit import tcw_pkg::*; #(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_mode,
   input  wire logic [CHAR_W-1:0] req_char_in,
   input  wire logic [6:0]        req_col,
   input  wire logic [4:0]        req_row,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [6:0]        rsp_cursor_col,
   output logic      [4:0]        rsp_cursor_row,
   output logic      [CHAR_W-1:0] rsp_cell_char,
   output logic      [ATTR_W-1:0] rsp_cell_attr,
   output logic                   rsp_scrolled,
   input  wire logic              csr_wr_en,
   input  wire logic [ATTR_W-1:0] csr_wr_data
);
   localparam int COL_W   = $clog2(COLS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int OFF_W   = $clog2(COLS * ROWS);
   localparam int ENTRY_W = OP_W + CHAR_W + COL_W + ROW_W + OFF_W;

   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic               q_push, q_full, q_not_empty;
   logic [ENTRY_W-1:0] q_entry, q_head;
   status_type         back_status;

   assign attr_in = csr_wr_en ? csr_wr_data : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcw_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_char_in (req_char_in),
      .req_col     (req_col),
      .req_row     (req_row),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   tcw_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (back_status.pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_head)
   );

   tcw_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .attr           (attr_ff),
      .q_valid        (q_not_empty),
      .q_data         (q_head),
      .status         (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_scrolled   (rsp_scrolled)
   );

   // A scroll always leaves the cursor at the start of the bottom row.
   `TCW_ASSERT_IMP(a_scroll_homes_col, clock, reset, rsp_valid && rsp_scrolled, rsp_cursor_col == '0)
   // The sequencer only takes work when the queue holds some and the result slot is free.
   `TCW_ASSERT_IMP(a_pop_needs_slot, clock, reset, back_status.pop, q_not_empty && !rsp_valid)
   // Nothing is executed until the power-on blanking pass has finished.
   `TCW_ASSERT_IMP(a_no_pop_in_init, clock, reset, back_status.init, !back_status.pop)
   // Only one transaction is in flight in the sequencer at a time.
   `TCW_ASSERT_NEXT(a_single_in_flight, clock, reset, back_status.pop, !back_status.pop)
endmodule
`default_nettype wire

// ===== bench/tb_text_console_writer_unit.sv =====
// Self-checking testbench for the text console writer unit.
module tb_text_console_writer_unit import tcw_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1880;
   localparam int PHASES       = 8;
   localparam int HOLD_CYCLES  = 400;
   // A scroll or the clear after reset keeps the block busy while it sweeps the screen, so
   // the limit leaves room for several of those back to back.
   localparam int STALL_LIMIT  = 20000;

   typedef struct packed {
      logic [1:0]        mode;
      logic [CHAR_W-1:0] ch;
      logic [6:0]        col;
      logic [4:0]        row;
   } console_req_type;

   typedef struct packed {
      logic [6:0]        cur_col;
      logic [4:0]        cur_row;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic              scrolled;
   } console_rsp_type;

   // Mirror of the screen and cursor; computes the reply each transaction should give.
   class console_mirror;
      localparam int CELLS = COLS_DEF * ROWS_DEF;
      logic [CELL_W-1:0] cells [CELLS];
      int unsigned       cursor;
      logic [ATTR_W-1:0] attr;
      console_rsp_type   due_replies [$];
      int unsigned       mismatches;

      function new();
         attr = ATTR_RESET;
         blank(0, CELLS);
         cursor = 0;
         mismatches = 0;
      endfunction

      function void blank(int unsigned lo, int unsigned hi);
         for (int unsigned i = lo; i < hi; i++) cells[i] = {attr, CH_SPACE};
      endfunction

      function int unsigned clamp(logic [6:0] col, logic [4:0] row);
         int unsigned c;
         int unsigned r;
         c = (col >= COLS_DEF) ? COLS_DEF - 1 : col;
         r = (row >= ROWS_DEF) ? ROWS_DEF - 1 : row;
         return c + r * COLS_DEF;
      endfunction

      function void set_attr(logic [ATTR_W-1:0] value);
         attr = value;
      endfunction

      function void take_request(console_req_type r);
         console_rsp_type   reply;
         logic [CELL_W-1:0] found;
         reply = '0;
         if (cursor >= CELLS) cursor = CELLS - 1;
         case (r.mode)
            MODE_PUT: begin
               if (r.ch == CH_NEWLINE) begin
                  cursor += COLS_DEF - cursor % COLS_DEF;
               end else if (r.ch == CH_TAB) begin
                  cursor += TAB_STEP - cursor % TAB_STEP;
               end else begin
                  cells[cursor] = {attr, r.ch};
                  cursor++;
               end
               if (cursor >= CELLS) begin
                  for (int unsigned i = 0; i < CELLS - COLS_DEF; i++)
                     cells[i] = cells[i + COLS_DEF];
                  blank(CELLS - COLS_DEF, CELLS);
                  cursor = CELLS - COLS_DEF;
                  reply.scrolled = 1'b1;
               end
            end
            MODE_MOVE: begin
               cursor = clamp(r.col, r.row);
            end
            MODE_READ: begin
               found = cells[clamp(r.col, r.row)];
               reply.cell_char = found[CHAR_W-1:0];
               reply.cell_attr = found[CELL_W-1:CHAR_W];
            end
            default: begin
               blank(0, CELLS);
               cursor = 0;
            end
         endcase
         reply.cur_col = 7'(cursor % COLS_DEF);
         reply.cur_row = 5'(cursor / COLS_DEF);
         due_replies.push_back(reply);
      endfunction

      function void check_reply(console_rsp_type got);
         console_rsp_type want;
         if (due_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: col %0d row %0d char %02h attr %02h scrolled %0b",
                        got.cur_col, got.cur_row, got.cell_char, got.cell_attr, got.scrolled);
            return;
         end
         want = due_replies.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("reply mismatch: expected col %0d row %0d char %02h attr %02h scrolled %0b",
                        want.cur_col, want.cur_row, want.cell_char, want.cell_attr,
                        want.scrolled);
               $display("                got      col %0d row %0d char %02h attr %02h scrolled %0b",
                        got.cur_col, got.cur_row, got.cell_char, got.cell_attr, got.scrolled);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_mode;
   logic [CHAR_W-1:0] req_char_in;
   logic [6:0]        req_col;
   logic [4:0]        req_row;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [6:0]        rsp_cursor_col;
   logic [4:0]        rsp_cursor_row;
   logic [CHAR_W-1:0] rsp_cell_char;
   logic [ATTR_W-1:0] rsp_cell_attr;
   logic              rsp_scrolled;
   logic              csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;

   console_mirror mirror = new();
   int unsigned   sent_items = 0;
   bit            req_idle_on = 1'b1;
   bit            rsp_idle_on;
   int unsigned   hold_requests;
   int unsigned   quiet_cycles = 0;

   text_console_writer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_char_in    (req_char_in),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_scrolled   (rsp_scrolled),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Observe both channels and the register port at each rising edge.
   always @(posedge clock) begin
      console_req_type req;
      console_rsp_type rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp = '{cur_col: rsp_cursor_col, cur_row: rsp_cursor_row,
                    cell_char: rsp_cell_char, cell_attr: rsp_cell_attr,
                    scrolled: rsp_scrolled};
            mirror.check_reply(rsp);
         end
         if (csr_wr_en) mirror.set_attr(csr_wr_data);
         if (req_valid && !req_stall) begin
            req = '{mode: req_mode, ch: req_char_in, col: req_col, row: req_row};
            mirror.take_request(req);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("** text_console_writer_unit: FAILED **");
         $finish;
      end
   end

   // Result side: random stalls, plus long hold-offs on request from the stimulus.
   initial begin
      int unsigned holds_done;
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= rsp_idle_on && ($urandom_range(99) < 29);
      end
   end

   task automatic send(console_req_type r);
      if (req_idle_on) begin
         while ($urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_mode    <= r.mode;
      req_char_in <= r.ch;
      req_col     <= r.col;
      req_row     <= r.row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic put_char(logic [CHAR_W-1:0] ch);
      send('{mode: MODE_PUT, ch: ch, col: 7'($urandom), row: 5'($urandom)});
   endtask

   task automatic move_to(logic [6:0] col, logic [4:0] row);
      send('{mode: MODE_MOVE, ch: 8'($urandom), col: col, row: row});
   endtask

   task automatic read_at(logic [6:0] col, logic [4:0] row);
      send('{mode: MODE_READ, ch: 8'($urandom), col: col, row: row});
   endtask

   task automatic wipe_screen();
      send('{mode: MODE_CLEAR, ch: 8'($urandom), col: 7'($urandom), row: 5'($urandom)});
   endtask

   // Stop offering and wait until every outstanding transaction has been answered.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.due_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_attr(logic [ATTR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly a cursor move followed by a short burst of text and read-backs of what was
   // written; moves near the end of the bottom row let the burst scroll the screen.
   task automatic run_sequence();
      int unsigned pick;
      int unsigned burst;
      int unsigned c0;
      int unsigned r0;
      pick = $urandom_range(99);
      if (pick < 2) begin
         wipe_screen();
      end else if (pick < 7) begin
         send('{mode: 2'($urandom), ch: 8'($urandom), col: 7'($urandom), row: 5'($urandom)});
      end else begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            c0 = $urandom_range(79, 70);
            r0 = ROWS_DEF - 1;
         end else if (pick < 30) begin
            c0 = $urandom_range(127);
            r0 = $urandom_range(31);
         end else begin
            c0 = $urandom_range(COLS_DEF - 1);
            r0 = $urandom_range(ROWS_DEF - 1);
         end
         move_to(7'(c0), 5'(r0));
         burst = $urandom_range(8, 1);
         repeat (burst) begin
            pick = $urandom_range(99);
            if (pick < 10) put_char(CH_NEWLINE);
            else if (pick < 18) put_char(CH_TAB);
            else put_char(8'($urandom));
         end
         repeat ($urandom_range(3)) begin
            if ($urandom_range(3) == 0) read_at(7'($urandom), 5'($urandom));
            else read_at(7'(c0 + $urandom_range(burst)), 5'(r0));
         end
      end
   endtask

   initial begin
      int unsigned       goal;
      logic [ATTR_W-1:0] attr_value;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= MODE_PUT;
      req_char_in   <= '0;
      req_col       <= '0;
      req_row       <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      rsp_idle_on   <= 1'b1;
      hold_requests <= 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Screen after reset, clamped coordinates, the zero byte, tab and newline, and
      // scrolls from a character and a newline at the last cell and a tab in the bottom row.
      read_at(7'd0, 5'd0);
      read_at(7'd127, 5'd31);
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CH_TAB);
      put_char(CH_NEWLINE);
      read_at(7'd0, 5'd0);
      read_at(7'd1, 5'd0);
      read_at(7'd2, 5'd0);
      move_to(7'd127, 5'd31);
      put_char(8'h5A);
      read_at(7'd79, 5'd23);
      read_at(7'd0, 5'd24);
      move_to(7'd76, 5'd24);
      put_char(CH_TAB);
      move_to(7'd79, 5'd24);
      put_char(CH_NEWLINE);
      move_to(7'd0, 5'd31);
      read_at(7'd79, 5'd23);
      drain();

      write_attr(8'hFF);
      wipe_screen();
      read_at(7'd40, 5'd12);
      move_to(7'd5, 5'd5);
      put_char(8'h80);
      read_at(7'd5, 5'd5);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: attr_value = 8'h00;
            2: attr_value = 8'h80;
            4: attr_value = 8'h01;
            6: attr_value = 8'h7F;
            7: attr_value = ATTR_RESET;
            default: attr_value = 8'($urandom);
         endcase
         write_attr(attr_value);
         // One phase runs with no idling on either side.
         req_idle_on = (ph != 3);
         rsp_idle_on <= (ph != 3);
         if (ph == 5) hold_requests <= hold_requests + 1;
         goal = sent_items + RANDOM_ITEMS / PHASES;
         while (sent_items < goal) run_sequence();
      end

      drain();
      repeat (12) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.due_replies.size() == 0) begin
         $display("** text_console_writer_unit: PASSED **");
      end else begin
         $display("** text_console_writer_unit: FAILED **");
      end
      $finish;
   end
endmodule
